[sv/ssd_pkg.sv]
// Shared types and constants for the sigmoid-scaled distance block.
// No dependencies; imported by the front, queue, back and top level.
package ssd_pkg;

    localparam int unsigned SumW = 48;
    localparam int unsigned DistW = 20;
    localparam logic [DistW-1:0] DIST_MAX = 20'hFFFFF;
    localparam logic [63:0] LN272_Q32 = 64'd4297681201;

    localparam int unsigned CfgSteepness = 0;
    localparam int unsigned CfgMidpoint = 1;
    localparam int unsigned CfgStraddle = 2;

    // One classified feature on its way from front to back
    typedef struct packed {
        logic [15:0] d;
        logic [15:0] e;
        logic        raw;
        logic        last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[sv/ssd_front.sv]
// Front part: accepts feature pairs, forms |a-b|, the straddle flag and the
// exponent table lookup. Depends on ssd_pkg.
module ssd_front #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  value_a,
    input  logic signed [15:0]  value_b,
    input  logic signed [15:0]  cutoff,
    input  logic                last,
    input  logic signed [15:0]  steepness,
    input  logic signed [15:0]  midpoint,
    input  logic                straddle_check,
    output logic                push,
    output ssd_pkg::job_t       job,
    input  ssd_pkg::fifo_status_t fifo_status
);
    import ssd_pkg::*;

    localparam int IdxW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;

    typedef logic [15:0] rom_t [EXP_TABLE_DEPTH];

    // shift-and-subtract quotient, used only while building the table
    function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], num[k]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [15:0] exp_entry(int unsigned i);
        logic [63:0] ax;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] z3;
        logic [63:0] v;
        logic [63:0] e;
        longint xi;
        xi = longint'((64'(i) * 64'd4096) / EXP_TABLE_DEPTH) - 2048;
        ax = (xi < 0) ? 64'(-xi) : 64'(xi);
        z = (ax * LN272_Q32) >> 18;
        z2 = (z * z) >> 30;
        z3 = (z2 * z) >> 30;
        v = ((64'd1 << 30) + z + (z2 >> 1) + long_div(z3, 64'd6)) >> 10;
        for (int k = 0; k < 8; k++)
        begin
            v = (v * v) >> 20;
        end
        if (xi >= 0)
        begin
            e = (v + 64'd2048) >> 12;
            return (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        e = long_div((64'd1 << 28) + (v >> 1), v);
        return e[15:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            r[i] = exp_entry(i);
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    // stage 1: difference, straddle flag, gain product
    logic               s1_valid_reg;
    logic [15:0]        s1_d_reg;
    logic               s1_raw_reg;
    logic               s1_last_reg;
    logic signed [33:0] s1_prod_reg;
    // stage 2: table entry
    logic               s2_valid_reg;
    logic [15:0]        s2_d_reg;
    logic [15:0]        s2_e_reg;
    logic               s2_raw_reg;
    logic               s2_last_reg;

    logic               s2_adv;
    logic               s1_adv;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic [15:0]        d_comb;
    logic signed [17:0] diff;
    logic signed [25:0] t_comb;
    logic signed [26:0] x_comb;
    logic [11:0]        u_comb;
    logic [31:0]        scaled;
    logic [IdxW-1:0]    idx;

    assign s2_adv = !s2_valid_reg || !fifo_status.full;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    always_comb
    begin
        if (value_a < value_b)
        begin
            lo = 17'(value_a);
            hi = 17'(value_b);
        end
        else
        begin
            lo = 17'(value_b);
            hi = 17'(value_a);
        end
        d_comb = 16'(hi - lo);
        diff = $signed({2'b00, d_comb}) - 18'(midpoint);
    end

    // clamp -floor(t/256) to [-2048, 2047] and map to a table row
    always_comb
    begin
        t_comb = 26'(s1_prod_reg >>> 8);
        x_comb = -27'(t_comb);
        if (x_comb < -27'sd2048)
            u_comb = 12'd0;
        else if (x_comb > 27'sd2047)
            u_comb = 12'd4095;
        else
            u_comb = 12'(x_comb + 27'sd2048);
        scaled = (32'(u_comb) * 32'(EXP_TABLE_DEPTH)) >> 12;
        idx = scaled[IdxW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_d_reg <= d_comb;
            s1_last_reg <= last;
            s1_raw_reg <= straddle_check && (lo < 17'(cutoff)) && (hi > 17'(cutoff));
            s1_prod_reg <= 34'(steepness) * 34'(diff);
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_d_reg <= s1_d_reg;
            s2_raw_reg <= s1_raw_reg;
            s2_last_reg <= s1_last_reg;
            s2_e_reg <= EXP_ROM[idx];
        end
    end

    assign push = s2_valid_reg && !fifo_status.full;
    assign job = '{d: s2_d_reg, e: s2_e_reg, raw: s2_raw_reg, last: s2_last_reg};

endmodule

[sv/ssd_fifo.sv]
// Two-entry queue between front and back.
// Depends on ssd_pkg for the job type.
module ssd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ssd_pkg::job_t         wr_job,
    input  logic                  pop,
    output ssd_pkg::job_t         rd_job,
    output ssd_pkg::fifo_status_t status
);
    import ssd_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    assign rd_job = mem_reg[rd_ptr_reg];
    assign status = '{full: count_reg == 2'd2, empty: count_reg == 2'd0};

endmodule

[sv/ssd_back.sv]
// Back part: iterative divide, square-and-accumulate, iterative square root.
// Depends on ssd_pkg.
module ssd_back #(
    parameter int MAX_FEATURES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssd_pkg::job_t         job,
    input  ssd_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [19:0]           distance
);
    import ssd_pkg::*;

    localparam int CntW = $clog2(MAX_FEATURES + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SQR  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t            state_reg;
    logic [2:0]        div_cnt_reg;
    logic [4:0]        root_cnt_reg;
    logic [23:0]       num_reg;
    logic [16:0]       div_reg;
    logic [16:0]       rem_reg;
    logic [15:0]       s_reg;
    logic [31:0]       sq_reg;
    logic              last_reg;
    logic [SumW-1:0]   sum_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [SumW-1:0]   val_reg;
    logic [25:0]       srem_reg;
    logic [23:0]       root_reg;
    logic [DistW-1:0]  dist_reg;

    logic [23:0]       num_next;
    logic [16:0]       rem_next;
    logic [17:0]       r;
    logic [26:0]       sr;
    logic [26:0]       trial;

    // four quotient bits a cycle
    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        for (int k = 0; k < 4; k++)
        begin
            r = {rem_next, num_next[23]};
            num_next = {num_next[22:0], 1'b0};
            if (r >= 18'(div_reg))
            begin
                r = r - 18'(div_reg);
                num_next[0] = 1'b1;
            end
            rem_next = r[16:0];
        end
    end

    always_comb
    begin
        sr = {srem_reg[24:0], val_reg[SumW-1 -: 2]};
        trial = 27'({root_reg, 2'b01});
    end

    assign pop = (state_reg == ST_IDLE) && !fifo_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!fifo_status.empty)
                        state_reg <= job.raw ? ST_SQR : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == 3'd5)
                        state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (last_reg)
                    begin
                        state_reg <= ST_ROOT;
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        if (cnt_reg < CntW'(MAX_FEATURES))
                        begin
                            sum_reg <= sum_reg + SumW'(sq_reg);
                            cnt_reg <= cnt_reg + CntW'(1);
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (root_cnt_reg == 5'd23)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                num_reg <= {job.d, 8'd0};
                div_reg <= 17'd256 + 17'(job.e);
                rem_reg <= '0;
                s_reg <= job.d;
                last_reg <= job.last;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                div_cnt_reg <= div_cnt_reg + 3'd1;
                s_reg <= num_next[15:0];
            end
            ST_SQR:
            begin
                sq_reg <= 32'(s_reg) * 32'(s_reg);
            end
            ST_ACC:
            begin
                if (cnt_reg < CntW'(MAX_FEATURES))
                    val_reg <= sum_reg + SumW'(sq_reg);
                else
                    val_reg <= sum_reg;
                srem_reg <= '0;
                root_reg <= '0;
                root_cnt_reg <= '0;
            end
            ST_ROOT:
            begin
                val_reg <= {val_reg[SumW-3:0], 2'b00};
                root_cnt_reg <= root_cnt_reg + 5'd1;
                if (sr >= trial)
                begin
                    srem_reg <= 26'(sr - trial);
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sr[25:0];
                    root_reg <= {root_reg[22:0], 1'b0};
                end
                dist_reg <= (root_reg[22:19] != 4'd0) ? DIST_MAX : DistW'({root_reg[18:0],
                            (sr >= trial)});
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign distance = dist_reg;

endmodule

[sv/sigmoid_scaled_distance.sv]
// Top level of the sigmoid-scaled distance block: configuration registers,
// front, queue and back. Depends on ssd_pkg, ssd_front, ssd_fifo, ssd_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | into      | in_valid / in_stall   | value_a, value_b, cutoff, last
//  out     | out of    | out_valid / out_stall | distance
//  cfg     | into      | cfg_we                | cfg_index, cfg_data
//
// The front takes one feature a cycle, unless a full queue stalls it, through
// two stages (gain multiply, table read) into a two-entry queue. The back
// handles one feature at a time: a feature kept raw skips the radix-16
// divider, a scaled one passes through it, and a feature marked last adds the
// square root plus the output transfer. Reset clears the valid flags, queue
// pointers, back state, feature count and sum; the exponent table is constant.
// A stalled result holds the back, which then backs up the queue and the front.
module sigmoid_scaled_distance #(
    parameter int MAX_FEATURES = 256,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] value_a,
    input  logic signed [15:0] value_b,
    input  logic signed [15:0] cutoff,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [19:0]        distance,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ssd_pkg::*;

    logic signed [15:0] steepness_reg;
    logic signed [15:0] midpoint_reg;
    logic               straddle_reg;

    logic         push;
    logic         pop;
    job_t         wr_job;
    job_t         rd_job;
    fifo_status_t fifo_status;

    // Hold configuration; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steepness_reg <= 16'sd256;
            midpoint_reg <= 16'sd0;
            straddle_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                2'(CfgSteepness): steepness_reg <= cfg_data;
                2'(CfgMidpoint):  midpoint_reg <= cfg_data;
                2'(CfgStraddle):  straddle_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ssd_front #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value_a(value_a),
        .value_b(value_b),
        .cutoff(cutoff),
        .last(last),
        .steepness(steepness_reg),
        .midpoint(midpoint_reg),
        .straddle_check(straddle_reg),
        .push(push),
        .job(wr_job),
        .fifo_status(fifo_status)
    );

    ssd_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wr_job(wr_job),
        .pop(pop),
        .rd_job(rd_job),
        .status(fifo_status)
    );

    ssd_back #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job(rd_job),
        .fifo_status(fifo_status),
        .pop(pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .distance(distance)
    );

endmodule

[sv/ssd_checker.sv]
// Port-level checker for sigmoid_scaled_distance, with its bind.
// Depends only on the top level's ports.
module ssd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [19:0] distance
);
    logic [3:0] pending_reg;
    logic       in_last_xfer;
    logic       out_xfer;

    assign in_last_xfer = in_valid && !in_stall && last;
    assign out_xfer = out_valid && !out_stall;

    // count vectors whose last feature is in but whose result is not yet out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_last_xfer && !out_xfer)
            pending_reg <= pending_reg + 4'd1;
        else if (out_xfer && !in_last_xfer)
            pending_reg <= pending_reg - 4'd1;
    end

    a_result_has_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without a completed vector");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !in_stall && !out_valid)
        else $error("handshake active after a reset edge");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(distance))
        else $error("stalled result changed");

endmodule

bind sigmoid_scaled_distance ssd_checker u_ssd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .distance(distance)
);
